/* rtl/bpc_pkg.sv */
package bpc_pkg;

    localparam int FRAME_WORDS = 4096;
    localparam int ADDR_W = $clog2(FRAME_WORDS);

    localparam int WORD_W = 64;
    localparam int INDEX_W = 12;
    localparam int IN_DATA_W = 80;
    localparam int OUT_USER_W = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_RESOLUTION_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_ENABLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_LOW = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DIRTY_TRACK_ENABLE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_DOUBLE = 3'd5;

    localparam logic [1:0] MODE_16C = 2'd0;
    localparam logic [1:0] MODE_4C = 2'd1;
    localparam logic [1:0] MODE_MONO = 2'd2;

    localparam logic [1:0] LAST_BEAT_16C = 2'd1;
    localparam logic [1:0] LAST_BEAT_4C = 2'd3;
    localparam logic [1:0] LAST_BEAT_MONO = 2'd0;

    typedef struct packed {
        logic [1:0]  resolution_mode;
        logic        palette_enable;
        logic [63:0] palette_low;
        logic [63:0] palette_high;
        logic        dirty_track_enable;
        logic        line_double;
    } cfg_t;

    // colour code of pixel k of the eight selected by beat
    function automatic logic [3:0] pixel_code(
        input logic [WORD_W-1:0] word,
        input logic              four_colour,
        input logic [1:0]        beat,
        input logic [2:0]        k
    );
        logic [3:0] pos;
        logic [3:0] v;
        begin
            v = 4'd0;
            if (four_colour)
            begin
                pos = ~{beat[0], k};
                if (beat[1])
                begin
                    v[0] = word[16 + pos];
                    v[1] = word[pos];
                end
                else
                begin
                    v[0] = word[48 + pos];
                    v[1] = word[32 + pos];
                end
            end
            else
            begin
                pos = ~{beat[0], k};
                v[0] = word[48 + pos];
                v[1] = word[32 + pos];
                v[2] = word[16 + pos];
                v[3] = word[pos];
            end
            pixel_code = v;
        end
    endfunction

endpackage

/* rtl/bpc_cfg_regs.sv */
module bpc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output bpc_pkg::cfg_t                     cfg
);

    bpc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resolution_mode <= bpc_pkg::MODE_16C;
            cfg_reg.palette_enable <= 1'b0;
            cfg_reg.palette_low <= '0;
            cfg_reg.palette_high <= '0;
            cfg_reg.dirty_track_enable <= 1'b0;
            cfg_reg.line_double <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bpc_pkg::REG_RESOLUTION_MODE:    cfg_reg.resolution_mode <= cfg_data[1:0];
                bpc_pkg::REG_PALETTE_ENABLE:     cfg_reg.palette_enable <= cfg_data[0];
                bpc_pkg::REG_PALETTE_LOW:        cfg_reg.palette_low <= cfg_data;
                bpc_pkg::REG_PALETTE_HIGH:       cfg_reg.palette_high <= cfg_data;
                bpc_pkg::REG_DIRTY_TRACK_ENABLE: cfg_reg.dirty_track_enable <= cfg_data[0];
                bpc_pkg::REG_LINE_DOUBLE:        cfg_reg.line_double <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* rtl/bpc_frame_store.sv */
module bpc_frame_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            look_en,
    input  logic [bpc_pkg::ADDR_W-1:0]      look_addr,
    input  logic [bpc_pkg::WORD_W-1:0]      cur_word,
    input  logic [bpc_pkg::ADDR_W-1:0]      cur_addr,
    input  logic                            commit,
    output logic                            changed,
    output logic                            busy
);

    localparam logic [bpc_pkg::ADDR_W:0] CLR_DONE = (bpc_pkg::ADDR_W+1)'(bpc_pkg::FRAME_WORDS);

    logic [bpc_pkg::WORD_W-1:0] frame_mem [bpc_pkg::FRAME_WORDS];
    logic                       valid_mem [bpc_pkg::FRAME_WORDS];

    logic [bpc_pkg::WORD_W-1:0] frame_rd_reg;
    logic                       valid_rd_reg;
    logic                       fwd_hit_reg;
    logic [bpc_pkg::WORD_W-1:0] fwd_data_reg;
    logic [bpc_pkg::ADDR_W:0]   clr_cnt_reg;
    logic [bpc_pkg::ADDR_W:0]   clr_cnt_next;

    logic                       wr_en;
    logic                       vwr_en;
    logic [bpc_pkg::ADDR_W-1:0] vwr_addr;
    logic                       vwr_data;
    logic                       eff_valid;
    logic [bpc_pkg::WORD_W-1:0] eff_data;

    assign busy = (clr_cnt_reg != CLR_DONE);
    assign clr_cnt_next = busy ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    // write back of a word that differs from the stored copy
    assign eff_valid = fwd_hit_reg | valid_rd_reg;
    assign eff_data = fwd_hit_reg ? fwd_data_reg : frame_rd_reg;
    assign changed = !eff_valid || (eff_data != cur_word);
    assign wr_en = commit && changed;

    assign vwr_en = busy || wr_en;
    assign vwr_addr = busy ? clr_cnt_reg[bpc_pkg::ADDR_W-1:0] : cur_addr;
    assign vwr_data = !busy;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[cur_addr] <= cur_word;
        end
        if (look_en)
        begin
            frame_rd_reg <= frame_mem[look_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vwr_en)
        begin
            valid_mem[vwr_addr] <= vwr_data;
        end
        if (look_en)
        begin
            valid_rd_reg <= valid_mem[look_addr];
        end
    end

    // lookup issued in the same cycle as a write to that entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            if (look_en)
            begin
                fwd_hit_reg <= wr_en && (cur_addr == look_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (look_en)
        begin
            fwd_data_reg <= cur_word;
        end
    end

endmodule

/* rtl/bpc_out_seq.sv */
module bpc_out_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bpc_pkg::cfg_t                      cfg,
    input  logic                               load,
    input  logic [bpc_pkg::WORD_W-1:0]         load_word,
    input  logic                               load_dirty,
    output logic                               can_load,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bpc_pkg::WORD_W-1:0]         m_axis_tdata,
    output logic [bpc_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    output logic                               m_axis_tlast
);

    logic                       o_valid_reg;
    logic [bpc_pkg::WORD_W-1:0] o_word_reg;
    logic [1:0]                 o_beat_reg;
    logic [1:0]                 o_end_reg;
    logic [1:0]                 o_mode_reg;
    logic                       o_dbl_reg;
    logic                       o_dirty_reg;

    logic [1:0]                 load_mode;
    logic [1:0]                 load_end;
    logic                       last_beat;
    logic                       xfer;
    logic [127:0]               palette;
    logic [bpc_pkg::WORD_W-1:0] pix_word;

    always_comb
    begin
        case (cfg.resolution_mode)
            bpc_pkg::MODE_16C:
            begin
                load_mode = bpc_pkg::MODE_16C;
                load_end = bpc_pkg::LAST_BEAT_16C;
            end
            bpc_pkg::MODE_4C:
            begin
                load_mode = bpc_pkg::MODE_4C;
                load_end = bpc_pkg::LAST_BEAT_4C;
            end
            default:
            begin
                load_mode = bpc_pkg::MODE_MONO;
                load_end = bpc_pkg::LAST_BEAT_MONO;
            end
        endcase
    end

    assign last_beat = (o_beat_reg == o_end_reg);
    assign xfer = o_valid_reg && m_axis_tready;
    assign can_load = !o_valid_reg || (m_axis_tready && last_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            o_beat_reg <= '0;
        end
        else if (load)
        begin
            o_valid_reg <= 1'b1;
            o_beat_reg <= '0;
        end
        else if (xfer)
        begin
            if (last_beat)
            begin
                o_valid_reg <= 1'b0;
            end
            else
            begin
                o_beat_reg <= o_beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            o_word_reg <= load_word;
            o_end_reg <= load_end;
            o_mode_reg <= load_mode;
            o_dbl_reg <= (load_mode == bpc_pkg::MODE_4C) && cfg.line_double;
            o_dirty_reg <= load_dirty;
        end
    end

    assign palette = {cfg.palette_high, cfg.palette_low};

    always_comb
    begin
        logic [3:0] v;
        pix_word = '0;
        for (int k = 0; k < 8; k++)
        begin
            v = bpc_pkg::pixel_code(o_word_reg, o_mode_reg == bpc_pkg::MODE_4C,
                                    o_beat_reg, 3'(k));
            if (cfg.palette_enable)
            begin
                pix_word[63 - 8*k -: 8] = palette[8*v +: 8];
            end
            else
            begin
                pix_word[63 - 8*k -: 8] = {4'd0, v};
            end
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata = (o_mode_reg == bpc_pkg::MODE_MONO) ? o_word_reg : pix_word;
    assign m_axis_tuser = {o_dirty_reg && last_beat, o_dbl_reg};
    assign m_axis_tlast = last_beat;

endmodule

/* rtl/bitplane_to_chunky_converter.sv */
// bitplane to chunky converter
// input stream: one 64-bit interleaved-bitplane video word per request, with its
// frame position and an end-of-chunk mark on tlast
// output stream: eight pixel bytes per request, leftmost pixel highest, in the
// colour modes; tuser carries the line-doubling hint and, on the final request
// of a chunk, the changed-chunk flag; tlast closes the requests caused by one
// input word; results per word: two in sixteen-colour, four in four-colour, one
// in mono, which passes the word through; the output sequencer sends one result
// per cycle while the receiver is ready, and words stream back to back; an
// accepted request passes the frame store lookup stage, then the output register
// the stored frame copy is read at acceptance; with tracking on, a changed word
// is written back as it moves to the output register, with a bypass when the
// next word hits the same entry
// after reset the valid store is swept, one entry a cycle, all 4096 entries;
// input tready stays low meanwhile, configuration writes are still taken
// when the receiver stalls the current result holds and one further word waits
// in the lookup stage before input tready drops
module bitplane_to_chunky_converter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // screen_word [63:0], word_index [75:64], zero pad [79:76]
    input  logic [bpc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // pixel_bytes [63:0]
    output logic [bpc_pkg::WORD_W-1:0]           m_axis_tdata,
    // double_this_line [0], chunk_dirty [1]
    output logic [bpc_pkg::OUT_USER_W-1:0]       m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    bpc_pkg::cfg_t cfg;

    logic                          s1_valid_reg;
    logic [bpc_pkg::WORD_W-1:0]    s1_word_reg;
    logic [bpc_pkg::ADDR_W-1:0]    s1_addr_reg;
    logic                          s1_last_reg;
    logic                          chunk_changed_reg;
    logic                          chunk_changed_next;

    logic                          accept;
    logic                          advance;
    logic                          can_load;
    logic                          changed;
    logic                          busy;
    logic                          commit;
    logic                          dirty;

    bpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance = s1_valid_reg && can_load;
    assign s_axis_tready = !busy && (!s1_valid_reg || advance);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign commit = advance && cfg.dirty_track_enable;

    bpc_frame_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .look_en   (accept),
        .look_addr (s_axis_tdata[bpc_pkg::WORD_W +: bpc_pkg::ADDR_W]),
        .cur_word  (s1_word_reg),
        .cur_addr  (s1_addr_reg),
        .commit    (commit),
        .changed   (changed),
        .busy      (busy)
    );

    assign dirty = cfg.dirty_track_enable && s1_last_reg && (chunk_changed_reg || changed);

    always_comb
    begin
        chunk_changed_next = chunk_changed_reg;
        if (advance)
        begin
            if (s1_last_reg)
            begin
                chunk_changed_next = 1'b0;
            end
            else if (cfg.dirty_track_enable && changed)
            begin
                chunk_changed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            chunk_changed_reg <= 1'b0;
        end
        else
        begin
            chunk_changed_reg <= chunk_changed_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= s_axis_tdata[bpc_pkg::WORD_W-1:0];
            s1_addr_reg <= s_axis_tdata[bpc_pkg::WORD_W +: bpc_pkg::ADDR_W];
            s1_last_reg <= s_axis_tlast;
        end
    end

    bpc_out_seq u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .load          (advance),
        .load_word     (s1_word_reg),
        .load_dirty    (dirty),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready
    ) else $error("input taken during valid store sweep");

    a_chunk_cleared_at_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg) |=> !chunk_changed_reg
    ) else $error("chunk change flag survives chunk end");

    a_dirty_only_tracked_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (cfg.dirty_track_enable && m_axis_tlast)
    ) else $error("chunk dirty flag outside a tracked final result");

endmodule

/* test/bitplane_to_chunky_converter_tb.sv */
module bitplane_to_chunky_converter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int PRINT_LIMIT = 100;
    localparam int PAD_W = bpc_pkg::IN_DATA_W - bpc_pkg::INDEX_W - bpc_pkg::WORD_W;

    typedef struct packed {
        logic [bpc_pkg::WORD_W-1:0] pixels;
        logic                       double_line;
        logic                       dirty;
        logic                       fin;
    } pixel_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [bpc_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [bpc_pkg::WORD_W-1:0]      m_axis_tdata;
    logic [bpc_pkg::OUT_USER_W-1:0]  m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // register copy and frame store of the converter
    logic [1:0]                 conv_mode = bpc_pkg::MODE_16C;
    logic                       conv_palette_on = 1'b0;
    logic [63:0]                conv_palette_low = '0;
    logic [63:0]                conv_palette_high = '0;
    logic                       conv_track_on = 1'b0;
    logic                       conv_line_double = 1'b1;
    bit [bpc_pkg::WORD_W-1:0]   stored_frame [bpc_pkg::FRAME_WORDS];
    bit                         stored_valid [bpc_pkg::FRAME_WORDS];
    bit                         chunk_touched;

    // video memory as the stimulus sees it
    bit [bpc_pkg::WORD_W-1:0]   screen_image [bpc_pkg::FRAME_WORDS];

    pixel_result_t     pending_pixels [$];
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    logic              hold_off = 1'b0;
    event              hold_off_go;

    bitplane_to_chunky_converter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver stall
    always
    begin
        @(hold_off_go);
        @(negedge clk) hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        @(negedge clk) hold_off = 1'b0;
    end

    task automatic note_error(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic logic [7:0] palette_entry(input logic [3:0] v);
        if (!conv_palette_on)
            return {4'd0, v};
        if (v[3])
            return conv_palette_high[8 * v[2:0] +: 8];
        return conv_palette_low[8 * v[2:0] +: 8];
    endfunction

    // eight pixels from plane words, plane 0 lowest weight
    function automatic logic [63:0] eight_pixels(
        input logic [15:0] p0,
        input logic [15:0] p1,
        input logic [15:0] p2,
        input logic [15:0] p3,
        input int          first
    );
        logic [63:0] acc;
        int          pos;
        acc = '0;
        for (int k = 0; k < 8; k++)
        begin
            pos = 15 - first - k;
            acc[56 - 8 * k +: 8] = palette_entry({p3[pos], p2[pos], p1[pos], p0[pos]});
        end
        return acc;
    endfunction

    task automatic convert_word(
        input logic [bpc_pkg::WORD_W-1:0]  w,
        input logic [bpc_pkg::INDEX_W-1:0] idx,
        input logic                        chunk_end
    );
        logic [63:0]   pix [4];
        int            n;
        logic          dbl;
        logic          dirty;
        pixel_result_t r;
        dbl = 1'b0;
        dirty = 1'b0;
        case (conv_mode)
            bpc_pkg::MODE_16C:
            begin
                pix[0] = eight_pixels(w[63:48], w[47:32], w[31:16], w[15:0], 0);
                pix[1] = eight_pixels(w[63:48], w[47:32], w[31:16], w[15:0], 8);
                n = 2;
            end
            bpc_pkg::MODE_4C:
            begin
                pix[0] = eight_pixels(w[63:48], w[47:32], 16'h0, 16'h0, 0);
                pix[1] = eight_pixels(w[63:48], w[47:32], 16'h0, 16'h0, 8);
                pix[2] = eight_pixels(w[31:16], w[15:0], 16'h0, 16'h0, 0);
                pix[3] = eight_pixels(w[31:16], w[15:0], 16'h0, 16'h0, 8);
                dbl = conv_line_double;
                n = 4;
            end
            default:
            begin
                pix[0] = w;
                n = 1;
            end
        endcase
        if (conv_track_on)
        begin
            if (!stored_valid[idx] || stored_frame[idx] != w)
            begin
                chunk_touched = 1'b1;
                stored_frame[idx] = w;
                stored_valid[idx] = 1'b1;
            end
            if (chunk_end)
                dirty = chunk_touched;
        end
        if (chunk_end)
            chunk_touched = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            r.pixels = pix[i];
            r.double_line = dbl;
            r.fin = (i == n - 1);
            r.dirty = r.fin ? dirty : 1'b0;
            pending_pixels.push_back(r);
        end
    endtask

    task automatic check_pixels();
        pixel_result_t want;
        if (pending_pixels.size() == 0)
        begin
            note_error($sformatf("unexpected result %h", m_axis_tdata));
            return;
        end
        want = pending_pixels.pop_front();
        if (m_axis_tdata !== want.pixels)
            note_error($sformatf("pixel_bytes %h, want %h", m_axis_tdata, want.pixels));
        if (m_axis_tuser[0] !== want.double_line)
            note_error($sformatf("double_this_line %b, want %b",
                                 m_axis_tuser[0], want.double_line));
        if (m_axis_tuser[1] !== want.dirty)
            note_error($sformatf("chunk_dirty %b, want %b", m_axis_tuser[1], want.dirty));
        if (m_axis_tlast !== want.fin)
            note_error($sformatf("last %b, want %b", m_axis_tlast, want.fin));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_pixels();
    end

    task automatic send_word(
        input logic [bpc_pkg::WORD_W-1:0]  w,
        input logic [bpc_pkg::INDEX_W-1:0] idx,
        input logic                        chunk_end
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{PAD_W{1'b0}}, idx, w};
        s_axis_tlast <= chunk_end;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        convert_word(w, idx, chunk_end);
    endtask

    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [bpc_pkg::CFG_INDEX_W-1:0] r,
                                  input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (r)
            bpc_pkg::REG_RESOLUTION_MODE:    conv_mode = value[1:0];
            bpc_pkg::REG_PALETTE_ENABLE:     conv_palette_on = value[0];
            bpc_pkg::REG_PALETTE_LOW:        conv_palette_low = value;
            bpc_pkg::REG_PALETTE_HIGH:       conv_palette_high = value;
            bpc_pkg::REG_DIRTY_TRACK_ENABLE: conv_track_on = value[0];
            bpc_pkg::REG_LINE_DOUBLE:        conv_line_double = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(
        input logic [1:0]  mode,
        input logic        palette_on,
        input logic [63:0] palette_low,
        input logic [63:0] palette_high,
        input logic        track_on,
        input logic        line_double
    );
        wait_until_idle();
        write_register(bpc_pkg::REG_RESOLUTION_MODE, 64'(mode));
        write_register(bpc_pkg::REG_PALETTE_ENABLE, 64'(palette_on));
        write_register(bpc_pkg::REG_PALETTE_LOW, palette_low);
        write_register(bpc_pkg::REG_PALETTE_HIGH, palette_high);
        write_register(bpc_pkg::REG_DIRTY_TRACK_ENABLE, 64'(track_on));
        write_register(bpc_pkg::REG_LINE_DOUBLE, 64'(line_double));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_palette();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed();
        // reset defaults: sixteen colours, no palette, no tracking
        send_word('0, '0, 1'b0);
        send_word('1, 12'hfff, 1'b1);
        send_word(64'h8000_4000_2000_1000, 12'd1, 1'b0);
        send_word(64'h0f0f_f0f0_5555_aaaa, 12'd2, 1'b1);

        // words never stored count as changed, then an unchanged chunk
        configure(bpc_pkg::MODE_4C, 1'b0, '0, '0, 1'b1, 1'b1);
        send_word('1, 12'd5, 1'b0);
        send_word(64'h5555_aaaa_aaaa_5555, 12'd6, 1'b1);
        send_word('1, 12'd5, 1'b0);
        send_word(64'h5555_aaaa_aaaa_5555, 12'd6, 1'b1);
        send_word(64'h5555_aaaa_aaaa_5554, 12'd6, 1'b1);

        configure(bpc_pkg::MODE_16C, 1'b1, '1, '0, 1'b1, 1'b0);
        send_word(64'h00ff_0f0f_3333_5555, 12'd7, 1'b0);
        send_word(64'hffff_0000_ffff_0000, 12'hfff, 1'b1);

        configure(bpc_pkg::MODE_4C, 1'b1, 64'h0706_0504_0302_0100, '1, 1'b0, 1'b0);
        send_word(64'h0f0f_0f0f_f0f0_f0f0, 12'd8, 1'b0);
        send_word(64'h5555_aaaa_0000_ffff, 12'd9, 1'b1);

        // palette ignored in mono
        configure(bpc_pkg::MODE_MONO, 1'b1, '1, '1, 1'b1, 1'b0);
        send_word(64'h0123_4567_89ab_cdef, 12'd10, 1'b1);
        send_word(64'hfedc_ba98_7654_3210, 12'd10, 1'b1);

        // chunk end clears the flag even with tracking off
        configure(MODE_UNUSED, 1'b0, '0, '0, 1'b1, 1'b1);
        send_word(64'h1234_5678_9abc_def0, 12'd100, 1'b0);
        configure(MODE_UNUSED, 1'b0, '0, '0, 1'b0, 1'b1);
        send_word(64'h1234_5678_9abc_def0, 12'd100, 1'b1);
        configure(MODE_UNUSED, 1'b0, '0, '0, 1'b1, 1'b1);
        send_word(64'h1234_5678_9abc_def0, 12'd100, 1'b1);
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_words);
        int                          sent;
        int                          seg_end;
        int                          len;
        int                          slot;
        logic [bpc_pkg::INDEX_W-1:0] idx;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        for (int seg = 0; seg < 3; seg++)
        begin
            configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      pick_palette(), pick_palette(),
                      $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
            seg_end = n_words * (seg + 1) / 3;
            while (sent < seg_end)
            begin
                len = $urandom_range(1, 6);
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: scattered words, chunk marks at random
                    for (int k = 0; k < len; k++)
                        send_word({$urandom, $urandom}, bpc_pkg::INDEX_W'($urandom),
                                  1'($urandom_range(0, 1)));
                end
                else
                begin
                    slot = $urandom_range(0, 15);
                    for (int k = 0; k < len; k++)
                    begin
                        idx = bpc_pkg::INDEX_W'(slot * 255 + k);
                        if ($urandom_range(0, 3) == 0)
                            screen_image[idx] = {$urandom, $urandom};
                        send_word(screen_image[idx], idx, k == len - 1);
                    end
                end
                sent += len;
            end
        end
    endtask

    task automatic test_backpressure();
        configure(bpc_pkg::MODE_4C, 1'b0, '0, '0, 1'b0, 1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> hold_off_go;
        for (int k = 0; k < 24; k++)
            send_word({$urandom, $urandom}, bpc_pkg::INDEX_W'($urandom), 1'(k % 4 == 3));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic(27, 45, 50);
        test_random_traffic(45, 27, 50);
        test_random_traffic(0, 0, 50);
        test_backpressure();
        wait_until_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* bitplane_to_chunky_converter.f */
rtl/bpc_pkg.sv
rtl/bpc_cfg_regs.sv
rtl/bpc_frame_store.sv
rtl/bpc_out_seq.sv
rtl/bitplane_to_chunky_converter.sv
test/bitplane_to_chunky_converter_tb.sv
